FILE: rtl/segmented_lfu_buffer_cache_top_macros.svh
// Assertion macros shared by the segmented LFU buffer cache RTL.
`ifndef SEGMENTED_LFU_BUFFER_CACHE_TOP_MACROS_SVH
`define SEGMENTED_LFU_BUFFER_CACHE_TOP_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define SLFU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define SLFU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/slfu_pkg.sv
// Package with sizes, entry types and control structs of the segmented LFU cache.
package slfu_pkg;

    localparam int LEFT_SLOTS   = 4;
    localparam int MIDDLE_SLOTS = 4;
    localparam int RIGHT_SLOTS  = 8;
    localparam int TOTAL_SLOTS  = LEFT_SLOTS + MIDDLE_SLOTS + RIGHT_SLOTS;
    localparam int RIGHT_START  = LEFT_SLOTS + MIDDLE_SLOTS;
    localparam int IDX_W        = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;

    localparam int SECTOR_W = 32;
    localparam int TRACK_W  = 32;
    localparam int COUNT_W  = 16;
    localparam int CMP_W    = 32;

    typedef logic [IDX_W-1:0] idx_t;

    // One cache entry
    typedef struct packed {
        logic                valid;
        logic [SECTOR_W-1:0] sector;
        logic [TRACK_W-1:0]  track;
        logic [COUNT_W-1:0]  count;
    } entry_t;

    // Insert request: rotate slots 0..slot down by one and place entry in slot 0
    typedef struct packed {
        logic                en;
        idx_t                slot;
        logic [SECTOR_W-1:0] sector;
        logic [TRACK_W-1:0]  track;
        logic [COUNT_W-1:0]  count;
    } ins_req_t;

    // Result of the shared comparator
    typedef struct packed {
        logic eq;
        logic le;
    } cmp_res_t;

endpackage

FILE: rtl/slfu_cmp.sv
// Shared comparator: equality and less-or-equal on one pair of operands.
module slfu_cmp
    import slfu_pkg::*;
(
    input  logic [CMP_W-1:0] a,
    input  logic [CMP_W-1:0] b,
    output cmp_res_t         res
);

    logic [CMP_W:0] diff;

    // Subtract once; the borrow gives a < b
    assign diff   = {1'b0, a} - {1'b0, b};
    assign res.eq = (a == b);
    assign res.le = diff[CMP_W] | res.eq;

endmodule

FILE: rtl/slfu_store.sv
// Entry storage: one read port at the scan index and a rotating insert.
module slfu_store
    import slfu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  idx_t     rd_idx,
    output entry_t   rd_entry,
    input  ins_req_t ins
);

    logic [TOTAL_SLOTS-1:0] valid_reg;
    logic [SECTOR_W-1:0]    sector_reg [TOTAL_SLOTS];
    logic [TRACK_W-1:0]     track_reg  [TOTAL_SLOTS];
    logic [COUNT_W-1:0]     count_reg  [TOTAL_SLOTS];

    // Read the entry under the scan index
    assign rd_entry.valid  = valid_reg[rd_idx];
    assign rd_entry.sector = sector_reg[rd_idx];
    assign rd_entry.track  = track_reg[rd_idx];
    assign rd_entry.count  = count_reg[rd_idx];

    // Shift valid bits down through the chosen slot, set slot 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ins.en)
        begin
            for (int j = TOTAL_SLOTS - 1; j > 0; j--)
            begin
                if (idx_t'(j) <= ins.slot)
                begin
                    valid_reg[j] <= valid_reg[j-1];
                end
            end
            valid_reg[0] <= 1'b1;
        end
    end

    // Shift payload the same way; entries that are not valid read as don't care
    always_ff @(posedge clk)
    begin
        if (ins.en)
        begin
            for (int j = TOTAL_SLOTS - 1; j > 0; j--)
            begin
                if (idx_t'(j) <= ins.slot)
                begin
                    sector_reg[j] <= sector_reg[j-1];
                    track_reg[j]  <= track_reg[j-1];
                    count_reg[j]  <= count_reg[j-1];
                end
            end
            sector_reg[0] <= ins.sector;
            track_reg[0]  <= ins.track;
            count_reg[0]  <= ins.count;
        end
    end

endmodule

FILE: rtl/segmented_lfu_buffer_cache_top.sv
// Top level of the segmented LFU buffer cache: sequencer, scan and result register.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tuser: kind; s_tdata: sector, track, use_count
//  m_*     | out | m_tvalid/m_tready  | m_tdata: hit (lookup requests only)
//
// A lookup walks the entries one per cycle through the shared comparator and stops at
// the first match or the last entry, then loads the result register once it is free.
// An insert scans for the first free slot or else the least used right-segment entry,
// then rotates the entries. No request is taken until the block idles.
// Reset clears all valid bits at once; no clearing pass is needed.
// A stalled result holds in the output register; the next request may enter meanwhile.
`include "segmented_lfu_buffer_cache_top_macros.svh"

module segmented_lfu_buffer_cache_top
    import slfu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // [31:0] sector, [63:32] track, [79:64] use_count
    input  logic        s_tuser,   // [0] kind: 0 lookup, 1 insert
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] hit, [7:1] zero
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_PUSH  = 2'd3;

    localparam logic       KIND_INSERT = 1'b1;
    localparam idx_t       LAST_IDX    = idx_t'(TOTAL_SLOTS - 1);
    localparam logic [IDX_W:0] RIGHT_IDX = (IDX_W + 1)'(RIGHT_START);
    localparam logic [COUNT_W:0] COUNT_INIT = (COUNT_W + 1)'(1 << COUNT_W);

    logic [1:0]          state_reg, state_next;
    idx_t                idx_reg, idx_next;
    idx_t                best_idx_reg, best_idx_next;
    logic [COUNT_W:0]    best_count_reg, best_count_next;
    idx_t                slot_reg, slot_next;
    logic                hit_reg, hit_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic                m_hit_reg, m_hit_next;

    logic                kind_reg;
    logic [SECTOR_W-1:0] sector_reg;
    logic [TRACK_W-1:0]  track_reg;
    logic [COUNT_W-1:0]  count_reg;

    entry_t              rd_entry;
    ins_req_t            ins;
    logic [CMP_W-1:0]    cmp_a, cmp_b;
    cmp_res_t            cmp;
    logic                in_right;
    logic                accept;
    logic                out_free;

    assign accept   = s_tvalid & s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign in_right = ({1'b0, idx_reg} >= RIGHT_IDX);

    // Storage and shared comparator
    slfu_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_idx   (idx_reg),
        .rd_entry (rd_entry),
        .ins      (ins)
    );

    // Route sectors for a lookup, counts for an insert
    assign cmp_a = (kind_reg == KIND_INSERT) ? CMP_W'(rd_entry.count) : rd_entry.sector;
    assign cmp_b = (kind_reg == KIND_INSERT) ? CMP_W'(best_count_reg) : sector_reg;

    slfu_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp)
    );

    // Rotate request while in the shift state
    assign ins.en     = (state_reg == ST_SHIFT);
    assign ins.slot   = slot_reg;
    assign ins.sector = sector_reg;
    assign ins.track  = track_reg;
    assign ins.count  = count_reg;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        best_idx_next   = best_idx_reg;
        best_count_next = best_count_reg;
        slot_next       = slot_reg;
        hit_next        = hit_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_hit_next      = m_hit_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next      = ST_SCAN;
                    idx_next        = '0;
                    best_idx_next   = LAST_IDX;
                    best_count_next = COUNT_INIT;
                end
            end
            ST_SCAN:
            begin
                if (kind_reg != KIND_INSERT)
                begin
                    // Lookup: stop at the first valid match or at the end
                    if (rd_entry.valid && cmp.eq)
                    begin
                        hit_next   = 1'b1;
                        state_next = ST_PUSH;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        hit_next   = 1'b0;
                        state_next = ST_PUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else if (!rd_entry.valid)
                begin
                    // Insert: first free slot wins
                    slot_next  = idx_reg;
                    state_next = ST_SHIFT;
                end
                else
                begin
                    // Track the least used right-segment entry, later index on ties
                    if (in_right && cmp.le)
                    begin
                        best_count_next = {1'b0, rd_entry.count};
                        best_idx_next   = idx_reg;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        slot_next  = (in_right && cmp.le) ? idx_reg : best_idx_reg;
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_SHIFT:
            begin
                state_next = ST_IDLE;
            end
            ST_PUSH:
            begin
                // Hold until the output register frees up
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_hit_next    = hit_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        best_idx_reg   <= best_idx_next;
        best_count_reg <= best_count_next;
        slot_reg       <= slot_next;
        hit_reg        <= hit_next;
        m_hit_reg      <= m_hit_next;
        if (accept)
        begin
            kind_reg   <= s_tuser;
            sector_reg <= s_tdata[SECTOR_W-1:0];
            track_reg  <= s_tdata[SECTOR_W+TRACK_W-1:SECTOR_W];
            count_reg  <= s_tdata[SECTOR_W+TRACK_W+COUNT_W-1:SECTOR_W+TRACK_W];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_hit_reg};

    // Checks
    `SLFU_ASSERT_NEXT(a_busy_after_request, accept, !s_tready, "request taken while busy")
    `SLFU_ASSERT_SAME(a_push_result, $rose(m_tvalid), $past(state_reg) == ST_PUSH, "stray result")
    `SLFU_ASSERT_NEXT(a_shift_one_cycle, state_reg == ST_SHIFT, s_tready, "rotate stuck")

endmodule
